### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define SDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/sdt_pkg.sv
package sdt_pkg;

    localparam int unsigned CoordW   = 24;
    localparam int unsigned ScrollW  = 15;
    localparam int unsigned TexW     = 20;
    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 24;

    localparam int unsigned DiffW    = CoordW + 1;   // vertex - origin
    localparam int unsigned DzW      = DiffW + 2;    // 3 * (vz - oz)
    localparam int unsigned SumW     = 52;           // dx^2 + dy^2 + dz^2
    localparam int unsigned RootW    = SumW / 2;
    localparam int unsigned NumW     = 42;           // DirScale * |d|
    localparam int unsigned DvdW     = NumW + 2;     // 2*num + len
    localparam int unsigned DvsW     = RootW + 1;    // 2*len
    localparam int unsigned QuoW     = 18;

    // 378 * 512: radius times Q16 shift over 128
    localparam int unsigned DirScale = 193536;

    localparam logic signed [TexW:0] TexMax = 21'sd524287;
    localparam logic signed [TexW:0] TexMin = -21'sd524288;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ORIGIN_X = 8'd0,
        CFG_ORIGIN_Y = 8'd1,
        CFG_ORIGIN_Z = 8'd2,
        CFG_SCROLL   = 8'd3
    } t_cfg_idx;

endpackage

### hw/rtl/sdt_if.sv
interface sdt_vtx_if import sdt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] vertex_z;
    logic                     last_vertex;
    modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface sdt_tex_if import sdt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [TexW-1:0] tex_s;
    logic signed [TexW-1:0] tex_t;
    logic                   zero_length;
    logic                   end_of_polygon;
    modport source (output valid, tex_s, tex_t, zero_length, end_of_polygon, input ready);
    modport sink   (input valid, tex_s, tex_t, zero_length, end_of_polygon, output ready);
endinterface

interface sdt_cfg_if import sdt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/sky_dome_texcoord_gen.sv
// Sky dome texture coordinate generator.
// i_vtx: one vertex per transaction (24-bit signed positions, 8 fraction bits,
//   plus a polygon-end mark). o_tex: one result per vertex, s and t in signed
//   Q3.16, a zero-length flag and the copied polygon-end mark.
// i_cfg: register writes (0..2 origin x/y/z, 3 scroll offset); always ready.
//   Other indexes are dropped. Write only while no vertex is in flight.
// Pipeline from vertex acceptance to o_tex.valid:
//   3 stages form the direction, squares and their sum, 26 stages extract the
//   integer square root one bit each, 1 stage builds the dividend, 18 stages
//   divide one quotient bit each (s and t side by side), 1 stage adds the
//   scroll and clamps into the output register.
// Throughput: one vertex per cycle while the pipeline is not stalled.
// Stall: the whole pipeline advances on one enable, which is low only while
//   the output register holds a result that is not taken; i_vtx.ready follows
//   it, so nothing is dropped or repeated.
// Reset clears all valid bits and the config registers to zero.
`include "assert_macros.svh"

module sky_dome_texcoord_gen import sdt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sdt_cfg_if.sink   i_cfg,
    sdt_vtx_if.sink   i_vtx,
    sdt_tex_if.source o_tex
);

    localparam int unsigned SqN = RootW;
    localparam int unsigned DvN = QuoW;

    logic signed [CoordW-1:0]  r_org_x, r_org_y, r_org_z;
    logic        [ScrollW-1:0] r_scroll;

    logic en;

    // config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_org_z  <= '0;
            r_scroll <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ORIGIN_X: r_org_x  <= i_cfg.data;
                CFG_ORIGIN_Y: r_org_y  <= i_cfg.data;
                CFG_ORIGIN_Z: r_org_z  <= i_cfg.data;
                CFG_SCROLL:   r_scroll <= i_cfg.data[ScrollW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: direction
    logic                    r_v1, r_l1;
    logic signed [DiffW-1:0] r_dx1, r_dy1;
    logic signed [DzW-1:0]   r_dz1;
    logic signed [DiffW-1:0] n_dzd;

    assign n_dzd = DiffW'(i_vtx.vertex_z) - DiffW'(r_org_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_vtx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1  <= i_vtx.last_vertex;
            r_dx1 <= DiffW'(i_vtx.vertex_x) - DiffW'(r_org_x);
            r_dy1 <= DiffW'(i_vtx.vertex_y) - DiffW'(r_org_y);
            r_dz1 <= (DzW'(n_dzd) <<< 1) + DzW'(n_dzd);
        end
    end

    // stage 2: magnitudes squared
    logic                r_v2, r_l2, r_sx2, r_sy2;
    logic [DiffW-1:0]    r_ax2, r_ay2;
    logic [2*DiffW-1:0]  r_qx2, r_qy2;
    logic [SumW-1:0]     r_qz2;
    logic [DiffW-1:0]    n_ax, n_ay;
    logic [DzW-2:0]      n_az;

    assign n_ax = r_dx1[DiffW-1] ? DiffW'(-r_dx1) : DiffW'(r_dx1);
    assign n_ay = r_dy1[DiffW-1] ? DiffW'(-r_dy1) : DiffW'(r_dy1);
    assign n_az = r_dz1[DzW-1]   ? (DzW-1)'(-r_dz1) : (DzW-1)'(r_dz1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l2  <= r_l1;
            r_sx2 <= r_dx1[DiffW-1];
            r_sy2 <= r_dy1[DiffW-1];
            r_ax2 <= n_ax;
            r_ay2 <= n_ay;
            r_qx2 <= n_ax * n_ax;
            r_qy2 <= n_ay * n_ay;
            r_qz2 <= SumW'(n_az * n_az);
        end
    end

    // square root pipeline; index 0 holds the sum and scaled numerators
    logic               r_sq_v   [0:SqN];
    logic               r_sq_l   [0:SqN];
    logic               r_sq_sx  [0:SqN];
    logic               r_sq_sy  [0:SqN];
    logic [NumW-1:0]    r_sq_nx  [0:SqN];
    logic [NumW-1:0]    r_sq_ny  [0:SqN];
    logic [SumW-1:0]    r_sq_rem [0:SqN];
    logic [RootW-1:0]   r_sq_rt  [0:SqN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_l[0]   <= r_l2;
            r_sq_sx[0]  <= r_sx2;
            r_sq_sy[0]  <= r_sy2;
            r_sq_nx[0]  <= NumW'(r_ax2 * DiffW'(DirScale));
            r_sq_ny[0]  <= NumW'(r_ay2 * DiffW'(DirScale));
            r_sq_rem[0] <= SumW'(r_qx2) + SumW'(r_qy2) + r_qz2;
            r_sq_rt[0]  <= '0;
        end
    end

    for (genvar j = 0; j < SqN; j++) begin : g_sqrt
        localparam int unsigned K = SqN - 1 - j;
        logic [SumW-1:0] trial;
        logic            fits;

        assign trial = (SumW'(r_sq_rt[j]) << (K + 1)) | (SumW'(1) << (2 * K));
        assign fits  = r_sq_rem[j] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_l[j+1]   <= r_sq_l[j];
                r_sq_sx[j+1]  <= r_sq_sx[j];
                r_sq_sy[j+1]  <= r_sq_sy[j];
                r_sq_nx[j+1]  <= r_sq_nx[j];
                r_sq_ny[j+1]  <= r_sq_ny[j];
                r_sq_rem[j+1] <= fits ? r_sq_rem[j] - trial : r_sq_rem[j];
                r_sq_rt[j+1]  <= fits ? (r_sq_rt[j] | (RootW'(1) << K)) : r_sq_rt[j];
            end
        end
    end

    // divider pipeline; index 0 holds round-to-nearest dividends
    logic              r_dv_v   [0:DvN];
    logic              r_dv_l   [0:DvN];
    logic              r_dv_sx  [0:DvN];
    logic              r_dv_sy  [0:DvN];
    logic              r_dv_z   [0:DvN];
    logic [DvsW-1:0]   r_dv_d   [0:DvN];
    logic [DvdW-1:0]   r_dv_rx  [0:DvN];
    logic [DvdW-1:0]   r_dv_ry  [0:DvN];
    logic [QuoW-1:0]   r_dv_qx  [0:DvN];
    logic [QuoW-1:0]   r_dv_qy  [0:DvN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sq_v[SqN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_l[0]  <= r_sq_l[SqN];
            r_dv_sx[0] <= r_sq_sx[SqN];
            r_dv_sy[0] <= r_sq_sy[SqN];
            r_dv_z[0]  <= (r_sq_rt[SqN] == '0);
            r_dv_d[0]  <= {r_sq_rt[SqN], 1'b0};
            r_dv_rx[0] <= {r_sq_nx[SqN], 1'b0} + DvdW'(r_sq_rt[SqN]);
            r_dv_ry[0] <= {r_sq_ny[SqN], 1'b0} + DvdW'(r_sq_rt[SqN]);
            r_dv_qx[0] <= '0;
            r_dv_qy[0] <= '0;
        end
    end

    for (genvar j = 0; j < DvN; j++) begin : g_div
        localparam int unsigned K = DvN - 1 - j;
        logic [DvdW:0] sub;
        logic          fx, fy;

        assign sub = (DvdW+1)'(r_dv_d[j]) << K;
        assign fx  = {1'b0, r_dv_rx[j]} >= sub;
        assign fy  = {1'b0, r_dv_ry[j]} >= sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_l[j+1]  <= r_dv_l[j];
                r_dv_sx[j+1] <= r_dv_sx[j];
                r_dv_sy[j+1] <= r_dv_sy[j];
                r_dv_z[j+1]  <= r_dv_z[j];
                r_dv_d[j+1]  <= r_dv_d[j];
                r_dv_rx[j+1] <= fx ? r_dv_rx[j] - DvdW'(sub) : r_dv_rx[j];
                r_dv_ry[j+1] <= fy ? r_dv_ry[j] - DvdW'(sub) : r_dv_ry[j];
                r_dv_qx[j+1] <= fx ? (r_dv_qx[j] | (QuoW'(1) << K)) : r_dv_qx[j];
                r_dv_qy[j+1] <= fy ? (r_dv_qy[j] | (QuoW'(1) << K)) : r_dv_qy[j];
            end
        end
    end

    // output stage: scroll, sign, clamp
    logic                   r_out_v, r_out_l, r_out_z;
    logic signed [TexW-1:0] r_out_s, r_out_t;
    logic signed [TexW:0]   n_base, n_px, n_py, n_sum_s, n_sum_t;

    assign n_base  = $signed({{(TexW-ScrollW){1'b0}}, r_scroll, 1'b0});
    assign n_px    = r_dv_z[DvN] ? '0 : $signed((TexW+1)'(r_dv_qx[DvN]));
    assign n_py    = r_dv_z[DvN] ? '0 : $signed((TexW+1)'(r_dv_qy[DvN]));
    assign n_sum_s = r_dv_sx[DvN] ? n_base - n_px : n_base + n_px;
    assign n_sum_t = r_dv_sy[DvN] ? n_base - n_py : n_base + n_py;

    assign en = !r_out_v || o_tex.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[DvN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_l <= r_dv_l[DvN];
            r_out_z <= r_dv_z[DvN];
            priority if (n_sum_s > TexMax) begin
                r_out_s <= TexMax[TexW-1:0];
            end else if (n_sum_s < TexMin) begin
                r_out_s <= TexMin[TexW-1:0];
            end else begin
                r_out_s <= n_sum_s[TexW-1:0];
            end
            priority if (n_sum_t > TexMax) begin
                r_out_t <= TexMax[TexW-1:0];
            end else if (n_sum_t < TexMin) begin
                r_out_t <= TexMin[TexW-1:0];
            end else begin
                r_out_t <= n_sum_t[TexW-1:0];
            end
        end
    end

    assign i_vtx.ready          = en;
    assign o_tex.valid          = r_out_v;
    assign o_tex.tex_s          = r_out_s;
    assign o_tex.tex_t          = r_out_t;
    assign o_tex.zero_length    = r_out_z;
    assign o_tex.end_of_polygon = r_out_l;

    // a zero-length direction leaves only the scroll term on both axes
    `SDT_ASSERT_NOW(a_zero_same, i_clk, i_rst_n, o_tex.valid && o_tex.zero_length, o_tex.tex_s == o_tex.tex_t)
    // a held result blocks new vertices
    `SDT_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, o_tex.valid && !o_tex.ready, !i_vtx.ready)
    // len >= |d| bounds the rounded quotient by the radius scale
    `SDT_ASSERT_NOW(a_quo_bound, i_clk, i_rst_n, r_dv_v[DvN] && !r_dv_z[DvN], (r_dv_qx[DvN] <= QuoW'(DirScale)) && (r_dv_qy[DvN] <= QuoW'(DirScale)))
    // a stalled pipeline keeps its last divider stage
    `SDT_ASSERT_NEXT(a_hold_div, i_clk, i_rst_n, !en, $stable(r_dv_qx[DvN]) && $stable(r_dv_v[DvN]))

endmodule
